// ===== sv/mandelbrot_escape_time_defines.svh =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_defines.svh
// Assertion macros used by the escape-time engine.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_DEFINES_SVH

// check that cons holds in the same cycle as ante
`define MBE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check that cons holds in the cycle after ante
`define MBE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mbe_pkg.sv =====
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared widths, register codes, reset values and the config record.
// ----------------------------------------------------------------------------
package mbe_pkg;

  // default number format: signed Q4.28
  localparam int COORD_BITS_DEF  = 32;
  localparam int FRAC_BITS_DEF   = 28;
  localparam int QUEUE_DEPTH_DEF = 2;

  // fixed field widths
  localparam int IDX_BITS       = 12;
  localparam int SIZE_BITS      = 13;
  localparam int LIMIT_BITS     = 16;
  localparam int REG_BITS       = 32;
  localparam int CFG_INDEX_BITS = 3;

  // register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_X_MIN  = 3'd0,
    REG_X_MAX  = 3'd1,
    REG_Y_MIN  = 3'd2,
    REG_Y_MAX  = 3'd3,
    REG_WIDTH  = 3'd4,
    REG_HEIGHT = 3'd5,
    REG_LIMIT  = 3'd6
  } mbe_reg_t;

  // reset values
  localparam logic [REG_BITS-1:0]   RST_X_MIN  = 32'hE000_0000;
  localparam logic [REG_BITS-1:0]   RST_X_MAX  = 32'h1000_0000;
  localparam logic [REG_BITS-1:0]   RST_Y_MIN  = 32'hE800_0000;
  localparam logic [REG_BITS-1:0]   RST_Y_MAX  = 32'h1800_0000;
  localparam logic [SIZE_BITS-1:0]  RST_WIDTH  = 13'd1024;
  localparam logic [SIZE_BITS-1:0]  RST_HEIGHT = 13'd1024;
  localparam logic [LIMIT_BITS-1:0] RST_LIMIT  = 16'd255;

  // configuration record
  typedef struct packed {
    logic [REG_BITS-1:0]   x_min;
    logic [REG_BITS-1:0]   x_max;
    logic [REG_BITS-1:0]   y_min;
    logic [REG_BITS-1:0]   y_max;
    logic [SIZE_BITS-1:0]  image_width;
    logic [SIZE_BITS-1:0]  image_height;
    logic [LIMIT_BITS-1:0] iteration_limit;
  } mbe_cfg_t;

endpackage

// ===== sv/mbe_div.sv =====
// ----------------------------------------------------------------------------
// mbe_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mbe_div #(
  parameter int NUM_BITS = 44
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  logic [NUM_BITS-1:0]          num,
  input  logic [mbe_pkg::SIZE_BITS-1:0] den,
  output logic [NUM_BITS-1:0]          quo,
  output logic                         done
);
  import mbe_pkg::*;

  localparam int CNT_BITS = $clog2(NUM_BITS + 1);

  logic                 run_r, run_nxt;
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic [NUM_BITS-1:0]  acc_r, acc_nxt;
  logic [SIZE_BITS-1:0] rem_r, rem_nxt;
  logic [SIZE_BITS-1:0] den_r, den_nxt;
  logic [SIZE_BITS:0]   trial;
  logic [SIZE_BITS:0]   diff;
  logic                 ge;

  // trial subtract of the next dividend bit
  assign trial = {rem_r, acc_r[NUM_BITS-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  // load, then shift quotient bits in where the dividend leaves
  always_comb begin
    run_nxt = run_r;
    cnt_nxt = cnt_r;
    acc_nxt = acc_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    if (load) begin
      run_nxt = 1'b1;
      cnt_nxt = CNT_BITS'(NUM_BITS);
      acc_nxt = num;
      rem_nxt = '0;
      den_nxt = den;
    end else if (run_r) begin
      acc_nxt = {acc_r[NUM_BITS-2:0], ge};
      rem_nxt = ge ? diff[SIZE_BITS-1:0] : trial[SIZE_BITS-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_BITS'(1)) begin
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign quo  = acc_r;
  assign done = !run_r;

endmodule

// ===== sv/mbe_front.sv =====
// ----------------------------------------------------------------------------
// mbe_front
// Accepts pixel items and maps column and row to a point of the plane.
// ----------------------------------------------------------------------------
module mbe_front #(
  parameter int COORD_BITS = mbe_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [mbe_pkg::IDX_BITS-1:0] in_column,
  input  logic [mbe_pkg::IDX_BITS-1:0] in_row,
  input  mbe_pkg::mbe_cfg_t            cfg,
  input  logic                         q_full,
  output logic                         q_push,
  output logic [COORD_BITS-1:0]        q_x,
  output logic [COORD_BITS-1:0]        q_y
);
  import mbe_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int QW = COORD_BITS + IDX_BITS;
  localparam int SW = COORD_BITS + IDX_BITS + 2;
  localparam logic [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_MUL  = 5'b00010,
    F_DIV  = 5'b00100,
    F_SAT  = 5'b01000,
    F_PUSH = 5'b10000
  } fstate_t;

  fstate_t state_r, state_nxt;

  logic [IDX_BITS-1:0] col_r, col_nxt;
  logic [IDX_BITS-1:0] row_r, row_nxt;
  logic [CB-1:0]       xlo_r, xlo_nxt, ylo_r, ylo_nxt;
  logic                xneg_r, xneg_nxt, yneg_r, yneg_nxt;
  logic                xdeg_r, xdeg_nxt, ydeg_r, ydeg_nxt;
  logic [CB-1:0]       x_r, x_nxt, y_r, y_nxt;

  logic [CB-1:0]        xlo_c, xhi_c, ylo_c, yhi_c;
  logic [CB:0]          xdif, ydif, xmag, ymag;
  logic [QW-1:0]        xprod, yprod, xquo, yquo;
  logic [SIZE_BITS-1:0] xden, yden;
  logic                 div_load, xdone, ydone;

  // read a coordinate register in the working format
  function automatic logic [CB-1:0] coord_of(input logic [REG_BITS-1:0] v);
    logic [63:0] e;
    e = {32'b0, v};
    return e[CB-1:0];
  endfunction

  // offset the corner by the quotient and clamp to the format
  function automatic logic [CB-1:0] place(input logic [CB-1:0] lo, input logic neg,
                                          input logic [QW-1:0] q);
    logic [SW-1:0]    s;
    logic [SW-CB:0]   top;
    s = neg ? ({{(SW-CB){lo[CB-1]}}, lo} - {2'b00, q})
            : ({{(SW-CB){lo[CB-1]}}, lo} + {2'b00, q});
    top = s[SW-1:CB-1];
    if ((&top) || !(|top)) begin
      return s[CB-1:0];
    end
    return s[SW-1] ? CMIN : CMAX;
  endfunction

  // corner span as sign and magnitude, times the index
  always_comb begin
    xlo_c = coord_of(cfg.x_min);
    xhi_c = coord_of(cfg.x_max);
    ylo_c = coord_of(cfg.y_min);
    yhi_c = coord_of(cfg.y_max);
    xdif  = {xhi_c[CB-1], xhi_c} - {xlo_c[CB-1], xlo_c};
    ydif  = {yhi_c[CB-1], yhi_c} - {ylo_c[CB-1], ylo_c};
    xmag  = xdif[CB] ? (~xdif + 1'b1) : xdif;
    ymag  = ydif[CB] ? (~ydif + 1'b1) : ydif;
    xprod = QW'(xmag[CB-1:0]) * QW'(col_r);
    yprod = QW'(ymag[CB-1:0]) * QW'(row_r);
    xden  = cfg.image_width - 1'b1;
    yden  = cfg.image_height - 1'b1;
  end

  mbe_div #(.NUM_BITS(QW)) u_div_x (
    .clk  (clk),
    .rst_n(rst_n),
    .load (div_load),
    .num  (xprod),
    .den  (xden),
    .quo  (xquo),
    .done (xdone)
  );

  mbe_div #(.NUM_BITS(QW)) u_div_y (
    .clk  (clk),
    .rst_n(rst_n),
    .load (div_load),
    .num  (yprod),
    .den  (yden),
    .quo  (yquo),
    .done (ydone)
  );

  // sequence one item: take, multiply, divide, place, hand over
  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    xlo_nxt   = xlo_r;
    ylo_nxt   = ylo_r;
    xneg_nxt  = xneg_r;
    yneg_nxt  = yneg_r;
    xdeg_nxt  = xdeg_r;
    ydeg_nxt  = ydeg_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    div_load  = 1'b0;
    q_push    = 1'b0;
    case (state_r)
      F_IDLE: begin
        if (start) begin
          col_nxt   = in_column;
          row_nxt   = in_row;
          state_nxt = F_MUL;
        end
      end
      F_MUL: begin
        div_load  = 1'b1;
        xlo_nxt   = xlo_c;
        ylo_nxt   = ylo_c;
        xneg_nxt  = xdif[CB];
        yneg_nxt  = ydif[CB];
        xdeg_nxt  = cfg.image_width < SIZE_BITS'(2);
        ydeg_nxt  = cfg.image_height < SIZE_BITS'(2);
        state_nxt = F_DIV;
      end
      F_DIV: begin
        if (xdone && ydone) begin
          state_nxt = F_SAT;
        end
      end
      F_SAT: begin
        x_nxt     = xdeg_r ? xlo_r : place(xlo_r, xneg_r, xquo);
        y_nxt     = ydeg_r ? ylo_r : place(ylo_r, yneg_r, yquo);
        state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    col_r  <= col_nxt;
    row_r  <= row_nxt;
    xlo_r  <= xlo_nxt;
    ylo_r  <= ylo_nxt;
    xneg_r <= xneg_nxt;
    yneg_r <= yneg_nxt;
    xdeg_r <= xdeg_nxt;
    ydeg_r <= ydeg_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
  end

  assign busy = state_r != F_IDLE;
  assign q_x  = x_r;
  assign q_y  = y_r;

endmodule

// ===== sv/mbe_queue.sv =====
// ----------------------------------------------------------------------------
// mbe_queue
// Small flip-flop FIFO of mapped points between front and back.
// ----------------------------------------------------------------------------
module mbe_queue #(
  parameter int WIDTH = 2 * mbe_pkg::COORD_BITS_DEF,
  parameter int DEPTH = mbe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             empty
);
  import mbe_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  // advance pointers with wrap
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wr_r] <= din;
    end
  end

  assign dout  = mem_r[rd_r];
  assign full  = cnt_r == CW'(DEPTH);
  assign empty = cnt_r == '0;

endmodule

// ===== sv/mbe_back.sv =====
// ----------------------------------------------------------------------------
// mbe_back
// Escape-time iteration z = z^2 + c in saturating fixed point.
// ----------------------------------------------------------------------------
module mbe_back #(
  parameter int COORD_BITS = mbe_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = mbe_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_empty,
  output logic                           q_pop,
  input  logic [COORD_BITS-1:0]          q_x,
  input  logic [COORD_BITS-1:0]          q_y,
  input  logic [mbe_pkg::LIMIT_BITS-1:0] limit,
  output logic                           out_valid,
  output logic [mbe_pkg::LIMIT_BITS-1:0] out_iteration_count
);
  import mbe_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int FB = FRAC_BITS;
  localparam int PB = 2 * COORD_BITS;
  localparam int IB = LIMIT_BITS + 1;
  localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};
  localparam logic signed [CB-1:0] ONE  = {{(CB-1){1'b0}}, 1'b1};
  localparam logic signed [CB-1:0] FOUR =
    (FRAC_BITS + 2 < COORD_BITS - 1) ? (ONE << (FRAC_BITS + 2)) : CMAX;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_MUL  = 3'b010,
    B_UPD  = 3'b100
  } bstate_t;

  bstate_t state_r, state_nxt;

  logic signed [CB-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [CB-1:0] zr_r, zr_nxt, zi_r, zi_nxt;
  logic signed [CB-1:0] sqr_r, sqr_nxt, sqi_r, sqi_nxt, pri_r, pri_nxt;
  logic [IB-1:0]        iter_r, iter_nxt;
  logic                 ov_r, ov_nxt;
  logic [IB-1:0]        cnt_r, cnt_nxt;
  logic signed [CB-1:0] mag;
  logic                 keep_going;

  // clamp a one-bit-grown result back to the format
  function automatic logic signed [CB-1:0] clamp1(input logic [CB:0] s);
    if (s[CB] != s[CB-1]) begin
      return s[CB] ? CMIN : CMAX;
    end
    return s[CB-1:0];
  endfunction

  function automatic logic signed [CB-1:0] sat_add(input logic signed [CB-1:0] a,
                                                   input logic signed [CB-1:0] b);
    return clamp1({a[CB-1], a} + {b[CB-1], b});
  endfunction

  function automatic logic signed [CB-1:0] sat_sub(input logic signed [CB-1:0] a,
                                                   input logic signed [CB-1:0] b);
    return clamp1({a[CB-1], a} - {b[CB-1], b});
  endfunction

  // product floored to the fraction point, clamped
  function automatic logic signed [CB-1:0] fx_mul(input logic signed [CB-1:0] a,
                                                  input logic signed [CB-1:0] b);
    logic signed [PB-1:0] p;
    logic [PB-FB-CB:0]    top;
    p   = a * b;
    top = p[PB-1:FB+CB-1];
    if ((&top) || !(|top)) begin
      return p[FB+CB-1:FB];
    end
    return p[PB-1] ? CMIN : CMAX;
  endfunction

  // escape test on the squares of the current z
  assign mag        = sat_add(sqr_r, sqi_r);
  assign keep_going = (mag < FOUR) && (iter_r <= {1'b0, limit});

  // alternate: multiply, then test and update
  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    zr_nxt    = zr_r;
    zi_nxt    = zi_r;
    sqr_nxt   = sqr_r;
    sqi_nxt   = sqi_r;
    pri_nxt   = pri_r;
    iter_nxt  = iter_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = 1'b0;
    q_pop     = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          x_nxt     = q_x;
          y_nxt     = q_y;
          zr_nxt    = '0;
          zi_nxt    = '0;
          iter_nxt  = '0;
          state_nxt = B_MUL;
        end
      end
      B_MUL: begin
        sqr_nxt   = fx_mul(zr_r, zr_r);
        sqi_nxt   = fx_mul(zi_r, zi_r);
        pri_nxt   = fx_mul(zr_r, zi_r);
        state_nxt = B_UPD;
      end
      B_UPD: begin
        if (keep_going) begin
          zr_nxt    = sat_add(sat_sub(sqr_r, sqi_r), x_r);
          zi_nxt    = sat_add(sat_add(pri_r, pri_r), y_r);
          iter_nxt  = iter_r + 1'b1;
          state_nxt = B_MUL;
        end else begin
          ov_nxt    = 1'b1;
          cnt_nxt   = iter_r - 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    zr_r   <= zr_nxt;
    zi_r   <= zi_nxt;
    sqr_r  <= sqr_nxt;
    sqi_r  <= sqi_nxt;
    pri_r  <= pri_nxt;
    iter_r <= iter_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign out_valid           = ov_r;
  assign out_iteration_count = cnt_r[LIMIT_BITS-1:0];

endmodule

// ===== sv/mandelbrot_escape_time.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Pixel engine: maps (column, row) to c and returns the escape iteration count.
//
//   channel  ports                                       handshake
//   input    start, busy, in_column, in_row              start && !busy
//   result   out_valid, out_iteration_count              one-cycle strobe
//   config   cfg_valid, cfg_ready, cfg_index, cfg_data   valid && ready
//
// The front handles one item at a time, paced by the two bit-serial dividers
// (one quotient bit per cycle); busy is high while it holds an item.
// The back alternates a multiply state and an add/test state per iteration,
// its three multipliers all working in the multiply state.
// A two-entry queue between them holds mapped points; the front stalls only
// when it is full. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_time_defines.svh"

module mandelbrot_escape_time #(
  parameter int COORD_BITS  = mbe_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS   = mbe_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = mbe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [mbe_pkg::IDX_BITS-1:0]       in_column,
  input  logic [mbe_pkg::IDX_BITS-1:0]       in_row,
  output logic                               out_valid,
  output logic [mbe_pkg::LIMIT_BITS-1:0]     out_iteration_count,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mbe_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [mbe_pkg::REG_BITS-1:0]       cfg_data
);
  import mbe_pkg::*;

  mbe_cfg_t cfg_r, cfg_nxt;

  logic                  q_push, q_pop, q_full, q_empty;
  logic [COORD_BITS-1:0] f_x, f_y, b_x, b_y;

  // register writes; unknown indexes drop
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_X_MIN:  cfg_nxt.x_min           = cfg_data;
        REG_X_MAX:  cfg_nxt.x_max           = cfg_data;
        REG_Y_MIN:  cfg_nxt.y_min           = cfg_data;
        REG_Y_MAX:  cfg_nxt.y_max           = cfg_data;
        REG_WIDTH:  cfg_nxt.image_width     = cfg_data[SIZE_BITS-1:0];
        REG_HEIGHT: cfg_nxt.image_height    = cfg_data[SIZE_BITS-1:0];
        REG_LIMIT:  cfg_nxt.iteration_limit = cfg_data[LIMIT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_min           <= RST_X_MIN;
      cfg_r.x_max           <= RST_X_MAX;
      cfg_r.y_min           <= RST_Y_MIN;
      cfg_r.y_max           <= RST_Y_MAX;
      cfg_r.image_width     <= RST_WIDTH;
      cfg_r.image_height    <= RST_HEIGHT;
      cfg_r.iteration_limit <= RST_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_ready = 1'b1;

  mbe_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_column(in_column),
    .in_row   (in_row),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_x      (f_x),
    .q_y      (f_y)
  );

  mbe_queue #(.WIDTH(2 * COORD_BITS), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .din  ({f_x, f_y}),
    .pop  (q_pop),
    .dout ({b_x, b_y}),
    .full (q_full),
    .empty(q_empty)
  );

  mbe_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_pop              (q_pop),
    .q_x                (b_x),
    .q_y                (b_y),
    .limit              (cfg_r.iteration_limit),
    .out_valid          (out_valid),
    .out_iteration_count(out_iteration_count)
  );

  // front never overruns the queue
  `MBE_ASSERT_IMP(a_no_push_full, q_push, !q_full, "push into full queue")
  // back never pops an empty queue
  `MBE_ASSERT_IMP(a_no_pop_empty, q_pop, !q_empty, "pop from empty queue")
  // a result never exceeds the limit
  `MBE_ASSERT_IMP(a_count_cap, out_valid,
                  out_iteration_count <= cfg_r.iteration_limit, "count above limit")
  // result strobes never come back to back
  `MBE_ASSERT_NXT(a_strobe_gap, out_valid, !out_valid, "back-to-back result strobe")

endmodule
